[sv/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants of the position track confirmer
// Transaction payloads, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int COORD_BITS   = 16;
	localparam int TIME_BITS    = 63;
	localparam int GAP_BITS     = 40;
	localparam int PEND_BITS    = 8;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 40;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_NEEDED_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLUSTER_RADIUS = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GAP        = 2'd2;

	// configuration reset values
	localparam logic [7:0]          NEEDED_SAMPLES_RST = 8'd3;
	localparam logic [15:0]         CLUSTER_RADIUS_RST = 16'd300;
	localparam logic [GAP_BITS-1:0] MAX_GAP_RST        = 40'd500000000;

	// operation codes
	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	typedef struct packed {
		logic                         op;
		logic signed [COORD_BITS-1:0] pos_x_mm;
		logic signed [COORD_BITS-1:0] pos_y_mm;
		logic                         pos_valid;
		logic [TIME_BITS-1:0]         sample_time_ns;
	} sample_t;

	typedef struct packed {
		logic                 accepted;
		logic                 confirmed_now;
		logic [PEND_BITS-1:0] pending_samples;
	} result_t;

endpackage

[sv/position_track_confirmer_core.sv]
// ----------------------------------------------------------------------------
// position_track_confirmer_core: confirms a stream of timestamped positions
// Running-mean clustering of 2D samples with time-gap checks, built around one
// shared multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one sample transaction at a time and returns exactly one
// result transaction for it. sample_stall is high from the cycle after a
// transaction is taken until its result has been loaded into the output
// register; a result may still wait there while the next sample is taken.
// Path from the accepting edge to the result: a clear or an unusable sample
// goes through the time check only; a sample that starts a new cluster at once
// adds the seed; a confirmed sample near the last accepted position goes
// through the time check, distance, three squaring steps and the radius
// compare; a new cluster after a distance compare adds the seed to those; a
// running-mean update adds the divider, which retires one quotient bit per
// cycle and runs once for x and once for y. A result that cannot leave
// because the previous one still waits in the output register is held in
// the last sequencer state until it can be loaded.
// All squares and the centre
// times count products go through a single (COORD_BITS+FRAC_BITS)-bit
// multiplier. Configuration writes are always taken (cfg_ready is tied high)
// and must only be issued while the block is idle; indexes beyond the three
// registers are ignored.
// ----------------------------------------------------------------------------
module position_track_confirmer_core #(
	parameter int FRAC_BITS  = 8,
	parameter int COUNT_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  ptc_pkg::sample_t                    sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ptc_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [ptc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	// width of a coordinate at fixed-point scale, also the multiplier width
	localparam int MW   = ptc_pkg::COORD_BITS + FRAC_BITS;
	localparam int CB   = COUNT_BITS;
	localparam int CW   = (CB > 8) ? CB : 8;
	localparam int CNTW = $clog2(MW);
	localparam int TW   = ptc_pkg::TIME_BITS;
	localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TIME = 4'd1;
	localparam logic [3:0] ST_DIFF = 4'd2;
	localparam logic [3:0] ST_SQX  = 4'd3;
	localparam logic [3:0] ST_SQY  = 4'd4;
	localparam logic [3:0] ST_SQR  = 4'd5;
	localparam logic [3:0] ST_CMP  = 4'd6;
	localparam logic [3:0] ST_NEW  = 4'd7;
	localparam logic [3:0] ST_MMUL = 4'd8;
	localparam logic [3:0] ST_MADD = 4'd9;
	localparam logic [3:0] ST_MDIV = 4'd10;
	localparam logic [3:0] ST_MEND = 4'd11;
	localparam logic [3:0] ST_FIN  = 4'd12;
	localparam logic [3:0] ST_DONE = 4'd13;

	logic [3:0] state_q;

	// configuration registers
	logic [7:0]                     needed_q;
	logic [15:0]                    radius_q;
	logic [ptc_pkg::GAP_BITS-1:0]   gap_q;

	// tracking state
	logic                                  conf_q;
	logic [TW-1:0]                         last_q;
	logic [CB-1:0]                         pend_q;
	logic signed [ptc_pkg::COORD_BITS-1:0] accx_q;
	logic signed [ptc_pkg::COORD_BITS-1:0] accy_q;
	logic signed [MW-1:0]                  cx_q;
	logic signed [MW-1:0]                  cy_q;

	// per-transaction working registers
	ptc_pkg::sample_t      item_q;
	logic                  acc_q;
	logic                  tgt_acc_q;
	logic                  axis_q;
	logic [MW-1:0]         magx_q;
	logic [MW-1:0]         magy_q;
	logic [2*MW-1:0]       prod_q;
	logic [2*MW:0]         sum_q;
	logic                  csign_q;
	logic                  nsign_q;
	logic [CB:0]           rem_q;
	logic [CB:0]           den_q;
	logic [MW-1:0]         dvd_q;
	logic [MW-1:0]         qt_q;
	logic [CNTW-1:0]       cnt_q;

	// output register
	ptc_pkg::result_t      result_q;
	logic                  res_valid_q;

	logic                  sample_take;
	logic                  result_load;

	assign sample_stall = (state_q != ST_IDLE);
	assign sample_take  = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = result_q;
	assign result_load  = (state_q == ST_DONE) && (!res_valid_q || !result_stall);

	// ------------------------------------------------------------------
	// Combinational helpers
	// ------------------------------------------------------------------
	logic signed [MW-1:0] fx_c;
	logic signed [MW-1:0] fy_c;
	logic signed [MW-1:0] refx_c;
	logic signed [MW-1:0] refy_c;
	logic signed [MW:0]   dx_c;
	logic signed [MW:0]   dy_c;
	logic [MW-1:0]        rad_fx_c;
	logic [7:0]           need_c;
	logic                 clear_c;
	logic                 drop_c;
	logic [TW-1:0]        tdiff_c;
	logic                 within_c;
	logic [CB-1:0]        pend_inc_c;
	logic                 confirm_c;

	// scale positions to the centre's fixed-point format
	assign fx_c = MW'($signed(item_q.pos_x_mm)) <<< FRAC_BITS;
	assign fy_c = MW'($signed(item_q.pos_y_mm)) <<< FRAC_BITS;

	// distance reference: last accepted position while confirmed, else centre
	assign refx_c = tgt_acc_q ? (MW'($signed(accx_q)) <<< FRAC_BITS) : cx_q;
	assign refy_c = tgt_acc_q ? (MW'($signed(accy_q)) <<< FRAC_BITS) : cy_q;
	assign dx_c   = (MW+1)'(fx_c) - (MW+1)'(refx_c);
	assign dy_c   = (MW+1)'(fy_c) - (MW+1)'(refy_c);

	assign rad_fx_c = MW'(radius_q) << FRAC_BITS;
	assign need_c   = (needed_q == 8'd0) ? 8'd1 : needed_q;

	// unusable sample or explicit clear wipes all tracking state
	assign clear_c = (item_q.op == ptc_pkg::OP_CLEAR) || !item_q.pos_valid ||
		(item_q.sample_time_ns == '0);

	// non-increasing time or an over-long gap drops confirmation
	assign tdiff_c = item_q.sample_time_ns - last_q;
	assign drop_c  = (last_q != '0) &&
		((item_q.sample_time_ns <= last_q) ||
		 ((gap_q != '0) && (tdiff_c > TW'(gap_q))));

	assign within_c   = (sum_q <= {1'b0, prod_q});
	assign pend_inc_c = (pend_q == COUNT_MAX) ? pend_q : pend_q + CB'(1);
	assign confirm_c  = (CW'(pend_inc_c) >= CW'(need_c));

	// ------------------------------------------------------------------
	// Shared multiplier: operands chosen by the sequencer
	// ------------------------------------------------------------------
	logic [MW-1:0]    mul_a;
	logic [MW-1:0]    mul_b;
	logic [2*MW-1:0]  mul_p;
	logic signed [MW-1:0] csel_c;
	logic [MW-1:0]    cmag_c;

	assign csel_c = axis_q ? cy_q : cx_q;
	assign cmag_c = csel_c[MW-1] ? MW'(-csel_c) : MW'(csel_c);

	always_comb begin
		unique case (state_q)
			ST_SQX: begin
				mul_a = magx_q;
				mul_b = magx_q;
			end
			ST_SQY: begin
				mul_a = magy_q;
				mul_b = magy_q;
			end
			ST_SQR: begin
				mul_a = rad_fx_c;
				mul_b = rad_fx_c;
			end
			ST_MMUL: begin
				mul_a = cmag_c;
				mul_b = MW'(pend_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// Running-mean numerator and divider step
	// ------------------------------------------------------------------
	logic signed [2*MW+1:0] num_c;
	logic [2*MW+1:0]        nmag_c;
	logic signed [MW-1:0]   fsel_c;
	logic [CB+1:0]          shifted_c;
	logic [CB+1:0]          trial_c;
	logic signed [MW-1:0]   qsig_c;

	assign fsel_c = axis_q ? fy_c : fx_c;
	assign num_c  = (csign_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q})) +
		(2*MW+2)'(fsel_c);
	assign nmag_c = num_c[2*MW+1] ? (2*MW+2)'(-num_c) : (2*MW+2)'(num_c);

	assign shifted_c = {rem_q, dvd_q[MW-1]};
	assign trial_c   = shifted_c - {1'b0, den_q};
	assign qsig_c    = nsign_q ? -$signed(qt_q) : $signed(qt_q);

	// centre to whole millimetres, truncating toward zero
	logic signed [MW:0] bias_x_c;
	logic signed [MW:0] bias_y_c;
	logic signed [MW:0] tx_c;
	logic signed [MW:0] ty_c;

	assign bias_x_c = cx_q[MW-1] ? (MW+1)'((1 << FRAC_BITS) - 1) : '0;
	assign bias_y_c = cy_q[MW-1] ? (MW+1)'((1 << FRAC_BITS) - 1) : '0;
	assign tx_c     = ((MW+1)'(cx_q) + bias_x_c) >>> FRAC_BITS;
	assign ty_c     = ((MW+1)'(cy_q) + bias_y_c) >>> FRAC_BITS;

	logic [CB+7:0] pend_wide_c;
	assign pend_wide_c = {8'd0, pend_q};

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= ptc_pkg::NEEDED_SAMPLES_RST;
			radius_q <= ptc_pkg::CLUSTER_RADIUS_RST;
			gap_q    <= ptc_pkg::MAX_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ptc_pkg::CFG_NEEDED_SAMPLES: needed_q <= cfg_data[7:0];
				ptc_pkg::CFG_CLUSTER_RADIUS: radius_q <= cfg_data[15:0];
				ptc_pkg::CFG_MAX_GAP:        gap_q    <= cfg_data[ptc_pkg::GAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and tracking state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			conf_q    <= 1'b0;
			last_q    <= '0;
			pend_q    <= '0;
			accx_q    <= '0;
			accy_q    <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			acc_q     <= 1'b0;
			tgt_acc_q <= 1'b0;
			axis_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_take) begin
						state_q <= ST_TIME;
					end
				end
				ST_TIME: begin
					acc_q <= 1'b0;
					if (clear_c) begin
						// wipe all tracking state, report zeros
						conf_q  <= 1'b0;
						last_q  <= '0;
						pend_q  <= '0;
						accx_q  <= '0;
						accy_q  <= '0;
						cx_q    <= '0;
						cy_q    <= '0;
						state_q <= ST_DONE;
					end else begin
						last_q <= item_q.sample_time_ns;
						if (drop_c) begin
							conf_q <= 1'b0;
							pend_q <= '0;
						end
						if (conf_q && !drop_c) begin
							// confirmed: compare against last accepted position
							tgt_acc_q <= 1'b1;
							state_q   <= ST_DIFF;
						end else if (drop_c || pend_q == '0) begin
							state_q <= ST_NEW;
						end else begin
							tgt_acc_q <= 1'b0;
							state_q   <= ST_DIFF;
						end
					end
				end
				ST_DIFF: begin
					state_q <= ST_SQX;
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (tgt_acc_q) begin
						if (within_c) begin
							// nearby confirmed sample: accept at once
							accx_q  <= item_q.pos_x_mm;
							accy_q  <= item_q.pos_y_mm;
							pend_q  <= '0;
							acc_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							// jump: break confirmation, start a new cluster
							conf_q  <= 1'b0;
							pend_q  <= '0;
							state_q <= ST_NEW;
						end
					end else if (within_c) begin
						axis_q  <= 1'b0;
						state_q <= ST_MMUL;
					end else begin
						state_q <= ST_NEW;
					end
				end
				ST_NEW: begin
					// seed the centre with this sample
					cx_q <= fx_c;
					cy_q <= fy_c;
					if (need_c == 8'd1) begin
						// centre is the sample itself, so whole mm are exact
						conf_q <= 1'b1;
						accx_q <= item_q.pos_x_mm;
						accy_q <= item_q.pos_y_mm;
						pend_q <= '0;
						acc_q  <= 1'b1;
					end else begin
						pend_q <= CB'(1);
					end
					state_q <= ST_DONE;
				end
				ST_MMUL: begin
					state_q <= ST_MADD;
				end
				ST_MADD: begin
					cnt_q   <= '0;
					state_q <= ST_MDIV;
				end
				ST_MDIV: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(MW - 1)) begin
						state_q <= ST_MEND;
					end
				end
				ST_MEND: begin
					if (axis_q) begin
						cy_q    <= qsig_c;
						state_q <= ST_FIN;
					end else begin
						cx_q    <= qsig_c;
						axis_q  <= 1'b1;
						state_q <= ST_MMUL;
					end
				end
				ST_FIN: begin
					if (confirm_c) begin
						conf_q <= 1'b1;
						accx_q <= tx_c[ptc_pkg::COORD_BITS-1:0];
						accy_q <= ty_c[ptc_pkg::COORD_BITS-1:0];
						pend_q <= '0;
						acc_q  <= 1'b1;
					end else begin
						pend_q <= pend_inc_c;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (result_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers (no reset needed)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (sample_take) begin
			item_q <= sample;
		end
		// hold the distance magnitudes for the squaring steps
		if (state_q == ST_DIFF) begin
			magx_q <= dx_c[MW] ? MW'(-dx_c) : MW'(dx_c);
			magy_q <= dy_c[MW] ? MW'(-dy_c) : MW'(dy_c);
		end
		if (state_q == ST_SQX || state_q == ST_SQY || state_q == ST_SQR ||
			state_q == ST_MMUL) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_SQY) begin
			sum_q <= {1'b0, prod_q};
		end
		if (state_q == ST_SQR) begin
			sum_q <= sum_q + {1'b0, prod_q};
		end
		if (state_q == ST_MMUL) begin
			csign_q <= csel_c[MW-1];
		end
		// load the divider: quotient fits MW bits, so the high part is below n+1
		if (state_q == ST_MADD) begin
			nsign_q <= num_c[2*MW+1];
			rem_q   <= nmag_c[MW+CB:MW];
			dvd_q   <= nmag_c[MW-1:0];
			den_q   <= (CB+1)'(pend_q) + (CB+1)'(1);
			qt_q    <= '0;
		end
		// one restoring division step per cycle
		if (state_q == ST_MDIV) begin
			dvd_q <= {dvd_q[MW-2:0], 1'b0};
			if (!trial_c[CB+1]) begin
				rem_q <= trial_c[CB:0];
				qt_q  <= {qt_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= shifted_c[CB:0];
				qt_q  <= {qt_q[MW-2:0], 1'b0};
			end
		end
		if (result_load) begin
			result_q.accepted        <= acc_q;
			result_q.confirmed_now   <= conf_q;
			result_q.pending_samples <= pend_wide_c[ptc_pkg::PEND_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Output register valid: advance on load, drop when taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (result_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

[tb/position_track_confirmer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_track_confirmer_core_tb: self-checking bench of the track confirmer
// Drives sample transactions through the valid/stall channel and predicts
// every result with a behavioral copy of the clustering and time checks. Each
// result transaction is compared field by field against the oldest expected
// one. Directed cases run first, then random traffic under several settings.
// ----------------------------------------------------------------------------
module position_track_confirmer_core_tb;

	localparam int FRAC        = 8;
	localparam int COUNT       = 8;
	localparam int PEND_MAX    = (1 << COUNT) - 1;
	localparam int CYCLE_LIMIT = 1000000;
	// longest result path is the running-mean update, through the divider twice
	localparam int TAIL_CYCLES = 80;
	localparam logic [ptc_pkg::TIME_BITS-1:0] T_MAX   = {ptc_pkg::TIME_BITS{1'b1}};
	localparam logic [ptc_pkg::GAP_BITS-1:0]  GAP_MAX = {ptc_pkg::GAP_BITS{1'b1}};

	typedef enum int {RX_FREE, RX_SPARSE, RX_HEAVY, RX_BLOCKY} rx_mode_t;
	typedef enum int {NZ_CLEAR, NZ_UNUSABLE, NZ_ZERO_TIME, NZ_STALE_TIME, NZ_LONG_GAP,
		NZ_WILD} noise_t;

	logic                              clk;
	logic                              arst_n;
	logic                              sample_valid;
	logic                              sample_stall;
	ptc_pkg::sample_t                  sample_bus;
	logic                              result_valid;
	logic                              result_stall;
	ptc_pkg::result_t                  result_bus;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [ptc_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [ptc_pkg::CFG_DATA_BITS-1:0] cfg_data;

	// bench copy of the configuration registers
	logic [7:0]                   cfg_need;
	logic [15:0]                  cfg_radius;
	logic [ptc_pkg::GAP_BITS-1:0] cfg_gap;

	// bench copy of the tracking state
	logic                          trk_confirmed;
	logic [ptc_pkg::TIME_BITS-1:0] trk_last_ns;
	int unsigned                   trk_pending;
	longint                        trk_acc_x, trk_acc_y;
	longint                        trk_ctr_x, trk_ctr_y;

	ptc_pkg::result_t              expected_verdicts[$];
	int unsigned                   mismatch_count = 0;
	int unsigned                   samples_sent = 0;
	int                            burst_left = 0;
	logic [ptc_pkg::TIME_BITS-1:0] stamp_ns = '0;
	rx_mode_t                      rx_mode = RX_FREE;
	int                            rx_run = 0;

	position_track_confirmer_core #(
		.FRAC_BITS (FRAC),
		.COUNT_BITS(COUNT)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample_bus),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result_bus),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	task automatic clear_track();
		trk_confirmed = 1'b0;
		trk_last_ns   = '0;
		trk_pending   = 0;
		trk_acc_x     = 0;
		trk_acc_y     = 0;
		trk_ctr_x     = 0;
		trk_ctr_y     = 0;
	endtask

	// Squared-distance test at fixed-point scale; all four inputs carry FRAC bits.
	function automatic bit within_radius(longint ax, longint ay, longint bx, longint by);
		longint unsigned dx, dy, rr;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		rr = {48'd0, cfg_radius} << FRAC;
		return dx * dx + dy * dy <= rr * rr;
	endfunction

	// Advance the tracking state by one sample and queue the result it must produce.
	task automatic predict_track_step(input ptc_pkg::sample_t s);
		longint           px, py, fx, fy, n, scale;
		int unsigned      need;
		ptc_pkg::result_t r;
		scale = longint'(1) << FRAC;
		px    = $signed(s.pos_x_mm);
		py    = $signed(s.pos_y_mm);
		fx    = px * scale;
		fy    = py * scale;
		need  = (cfg_need == 8'd0) ? 1 : cfg_need;
		r     = '0;
		if (s.op == ptc_pkg::OP_CLEAR || !s.pos_valid || s.sample_time_ns == '0) begin
			clear_track();
		end else begin
			// stale or late timestamp drops confirmation before the position logic
			if (trk_last_ns != '0 && (s.sample_time_ns <= trk_last_ns ||
					(cfg_gap != '0 && s.sample_time_ns - trk_last_ns > cfg_gap))) begin
				trk_confirmed = 1'b0;
				trk_pending   = 0;
			end
			trk_last_ns = s.sample_time_ns;
			if (trk_confirmed &&
					within_radius(fx, fy, trk_acc_x * scale, trk_acc_y * scale)) begin
				trk_acc_x   = px;
				trk_acc_y   = py;
				trk_pending = 0;
				r.accepted  = 1'b1;
			end else begin
				if (trk_confirmed) begin
					trk_confirmed = 1'b0;
					trk_pending   = 0;
				end
				if (trk_pending == 0 || !within_radius(fx, fy, trk_ctr_x, trk_ctr_y)) begin
					trk_ctr_x   = fx;
					trk_ctr_y   = fy;
					trk_pending = 1;
				end else begin
					// running mean, signed division truncates toward zero
					n = trk_pending;
					trk_ctr_x = (trk_ctr_x * n + fx) / (n + 1);
					trk_ctr_y = (trk_ctr_y * n + fy) / (n + 1);
					if (trk_pending < PEND_MAX)
						trk_pending++;
				end
				if (trk_pending >= need) begin
					trk_confirmed = 1'b1;
					trk_acc_x     = trk_ctr_x / scale;
					trk_acc_y     = trk_ctr_y / scale;
					trk_pending   = 0;
					r.accepted    = 1'b1;
				end
			end
		end
		r.confirmed_now   = trk_confirmed;
		r.pending_samples = trk_pending[ptc_pkg::PEND_BITS-1:0];
		expected_verdicts.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Sample and configuration drivers
	// ------------------------------------------------------------------

	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Build an observe transaction, clamping coordinates into the 16-bit range.
	function automatic ptc_pkg::sample_t make_obs(int x, int y,
			logic [ptc_pkg::TIME_BITS-1:0] t);
		ptc_pkg::sample_t s;
		if (x > 32767) x = 32767;
		if (x < -32768) x = -32768;
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		s.op             = ptc_pkg::OP_OBSERVE;
		s.pos_x_mm       = x[ptc_pkg::COORD_BITS-1:0];
		s.pos_y_mm       = y[ptc_pkg::COORD_BITS-1:0];
		s.pos_valid      = 1'b1;
		s.sample_time_ns = t;
		return s;
	endfunction

	// Advance the running timestamp, mostly within the gap limit, sometimes right at it.
	function automatic logic [ptc_pkg::TIME_BITS-1:0] step_stamp();
		longint unsigned dt;
		if (cfg_gap == '0)
			dt = $urandom_range(1, 1 << 20);
		else if ($urandom_range(0, 15) == 0)
			dt = cfg_gap;
		else
			dt = ({$urandom, $urandom} % cfg_gap) + 1;
		stamp_ns = stamp_ns + dt;
		return stamp_ns;
	endfunction

	// Present one sample, hold it until taken, then maybe idle for a while.
	task automatic send_sample(input ptc_pkg::sample_t s);
		int gap;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_bus   <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		predict_track_step(s);
		samples_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				sample_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// Drop valid and wait until every outstanding result has come back.
	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [ptc_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [ptc_pkg::CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			ptc_pkg::CFG_NEEDED_SAMPLES: cfg_need   = data[7:0];
			ptc_pkg::CFG_CLUSTER_RADIUS: cfg_radius = data[15:0];
			ptc_pkg::CFG_MAX_GAP:        cfg_gap    = data[ptc_pkg::GAP_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram all three registers once the block has gone idle.
	task automatic program_block(input logic [7:0] need, input logic [15:0] radius,
			input logic [ptc_pkg::GAP_BITS-1:0] gap);
		settle();
		write_cfg(ptc_pkg::CFG_NEEDED_SAMPLES, ptc_pkg::CFG_DATA_BITS'(need));
		write_cfg(ptc_pkg::CFG_CLUSTER_RADIUS, ptc_pkg::CFG_DATA_BITS'(radius));
		write_cfg(ptc_pkg::CFG_MAX_GAP, ptc_pkg::CFG_DATA_BITS'(gap));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: clear and unusable samples, a confirm, acceptance, jumps, time checks.
	task automatic test_directed_defaults();
		ptc_pkg::sample_t s;
		// clear with every other field at its top value
		s = make_obs(32767, 32767, T_MAX);
		s.op = ptc_pkg::OP_CLEAR;
		send_sample(s);
		s = make_obs(-32768, -32768, 63'd10);
		s.pos_valid = 1'b0;
		send_sample(s);
		send_sample(make_obs(5, 5, 63'd0));
		// three close samples confirm the stream, the fourth is taken at once
		send_sample(make_obs(100, 100, 63'd1000));
		send_sample(make_obs(150, 80, 63'd2000));
		send_sample(make_obs(120, 120, 63'd3000));
		send_sample(make_obs(200, 150, 63'd4000));
		// jump breaks confirmation, then repeated and late timestamps
		send_sample(make_obs(32767, 32767, 63'd5000));
		send_sample(make_obs(32767, 32767, 63'd5000));
		send_sample(make_obs(32767, 32767, 63'd500005001));
		send_sample(make_obs(32767, 32767, 63'd1000005001));
		send_sample(make_obs(-32768, -32768, 63'd1000005002));
		send_sample(make_obs(-32768, -32768, T_MAX));
		send_sample(make_obs(-32768, -32768, T_MAX));
		// a negative mean whose truncation toward zero differs from floor
		s = make_obs(0, 0, 63'd1);
		s.op = ptc_pkg::OP_CLEAR;
		send_sample(s);
		send_sample(make_obs(-1, -1, 63'd100));
		send_sample(make_obs(0, 0, 63'd200));
		send_sample(make_obs(0, 0, 63'd300));
	endtask

	// Register extremes: single-sample confirm, zero radius, tiny and huge gap limits.
	task automatic test_config_extremes();
		program_block(8'd1, 16'd0, 40'd1);
		send_sample(make_obs(7, -7, 63'd100));
		send_sample(make_obs(7, -7, 63'd101));
		send_sample(make_obs(8, -7, 63'd102));
		send_sample(make_obs(8, -7, 63'd104));
		// a needed count of zero behaves as one
		program_block(8'd0, 16'd0, 40'd1);
		send_sample(make_obs(0, 0, 63'd105));
		send_sample(make_obs(0, 1, 63'd106));
		// radius boundary: a 3-4-5 offset is exactly on the circle
		program_block(8'd2, 16'd5, GAP_MAX);
		send_sample(make_obs(0, 0, 63'd200));
		send_sample(make_obs(3, 4, 63'd201));
		send_sample(make_obs(4, 6, 63'd202));
		send_sample(make_obs(4, 12, 63'd203));
		send_sample(make_obs(4, 12, 63'd203 + 63'(GAP_MAX)));
		send_sample(make_obs(4, 12, 63'd203 + 63'(GAP_MAX) + 63'(GAP_MAX) + 63'd1));
	endtask

	// Largest needed count with the widest radius: the pending count climbs to the needed count and confirms.
	task automatic test_long_cluster();
		program_block(8'd255, 16'd65535, 40'd0);
		stamp_ns = 63'd1;
		repeat (300)
			send_sample(make_obs(int'($urandom_range(0, 40000)) - 20000,
				int'($urandom_range(0, 40000)) - 20000, step_stamp()));
	endtask

	// Random settings and traffic: mostly clusters of close samples, some noise.
	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [7:0]                   need;
		logic [15:0]                  radius;
		logic [ptc_pkg::GAP_BITS-1:0] gap;
		ptc_pkg::sample_t             s;
		int                           cx, cy, h, len, target;
		for (int p = 0; p < phases; p++) begin
			need = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 6))
				: 8'($urandom_range(0, 16));
			case ($urandom_range(0, 4))
				0: radius = 16'd0;
				1: radius = 16'($urandom_range(1, 50));
				2: radius = 16'($urandom_range(100, 2000));
				3: radius = 16'($urandom_range(0, 65535));
				default: radius = 16'd65535;
			endcase
			case ($urandom_range(0, 3))
				0: gap = '0;
				1: gap = ptc_pkg::GAP_BITS'($urandom_range(1, 1000000));
				2: gap = ptc_pkg::GAP_BITS'({$urandom, $urandom});
				default: gap = GAP_MAX;
			endcase
			program_block(need, radius, gap);
			target = samples_sent + per_phase;
			while (samples_sent < target) begin
				if ($urandom_range(0, 9) < 8) begin
					// a well-formed run of samples around one spot
					cx  = rand_coord();
					cy  = rand_coord();
					h   = (cfg_radius * 3) / 10;
					if (h > 20000) h = 20000;
					len = $urandom_range(1, ((cfg_need == 0) ? 1 : cfg_need) + 3);
					repeat (len) begin
						if ($urandom_range(0, 19) == 0)
							s = make_obs(rand_coord(), rand_coord(), step_stamp());
						else
							s = make_obs(cx + int'($urandom_range(0, 2 * h)) - h,
								cy + int'($urandom_range(0, 2 * h)) - h, step_stamp());
						send_sample(s);
					end
				end else begin
					s = make_obs(rand_coord(), rand_coord(), step_stamp());
					case (noise_t'($urandom_range(0, 5)))
						NZ_CLEAR: begin
							s.op        = ptc_pkg::OP_CLEAR;
							s.pos_valid = 1'($urandom_range(0, 1));
						end
						NZ_UNUSABLE:  s.pos_valid = 1'b0;
						NZ_ZERO_TIME: s.sample_time_ns = '0;
						NZ_STALE_TIME: s.sample_time_ns = stamp_ns - $urandom_range(0, 1000);
						NZ_LONG_GAP: begin
							if (cfg_gap != '0)
								stamp_ns = stamp_ns + cfg_gap + $urandom_range(1, 1000);
							else
								stamp_ns = stamp_ns + {$urandom_range(0, 65535), $urandom};
							s.sample_time_ns = stamp_ns;
						end
						default: begin
							stamp_ns         = 63'({$urandom, $urandom});
							s.sample_time_ns = stamp_ns;
						end
					endcase
					send_sample(s);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pattern and checking
	// ------------------------------------------------------------------

	// Switch between free flow, sparse stalls, heavy stalls and long blocks.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (rx_run == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_run  = $urandom_range(20, 200);
			end
			rx_run--;
			case (rx_mode)
				RX_FREE:   result_stall <= 1'b0;
				RX_SPARSE: result_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:  result_stall <= ($urandom_range(0, 1) == 0);
				default:   result_stall <= (rx_run % 16) < 10;
			endcase
		end
	end

	task automatic note_error(input string what, input ptc_pkg::result_t want,
			input ptc_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR %0t: %s: expected acc=%0d conf=%0d pend=%0d, %s%0d %s%0d %s%0d",
				$realtime, what, want.accepted, want.confirmed_now, want.pending_samples,
				"got acc=", got.accepted, "conf=", got.confirmed_now,
				"pend=", got.pending_samples);
	endtask

	// Compare each result transaction with the oldest expected one.
	always @(posedge clk) begin
		ptc_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_verdicts.size() == 0) begin
				note_error("result with nothing outstanding", '0, result_bus);
			end else begin
				want = expected_verdicts.pop_front();
				if (result_bus.accepted !== want.accepted ||
						result_bus.confirmed_now !== want.confirmed_now ||
						result_bus.pending_samples !== want.pending_samples)
					note_error("wrong result", want, result_bus);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence and end of run
	// ------------------------------------------------------------------

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("position_track_confirmer_core: mismatch");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_bus   = '0;
		cfg_valid    = 1'b0;
		cfg_index    = ptc_pkg::CFG_NEEDED_SAMPLES;
		cfg_data     = '0;
		cfg_need     = ptc_pkg::NEEDED_SAMPLES_RST;
		cfg_radius   = ptc_pkg::CLUSTER_RADIUS_RST;
		cfg_gap      = ptc_pkg::MAX_GAP_RST;
		clear_track();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_defaults();
		test_config_extremes();
		test_long_cluster();
		test_random_traffic(6, 240);

		// drain, then give the slowest path time to show any stray result
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_verdicts.size() == 0)
			$display("position_track_confirmer_core: match");
		else
			$display("position_track_confirmer_core: mismatch");
		$finish;
	end

endmodule
